// ----- rtl/core/lkv_pkg.sv -----
package lkv_pkg;

  localparam int ENTRIES     = 16;
  localparam int KEY_WIDTH   = 32;
  localparam int VALUE_WIDTH = 32;

  localparam int FIELD_W  = 32;
  localparam int CAP_W    = 5;
  localparam int KEY_BITS = (KEY_WIDTH < FIELD_W) ? KEY_WIDTH : FIELD_W;
  localparam int VAL_BITS = (VALUE_WIDTH < FIELD_W) ? VALUE_WIDTH : FIELD_W;
  localparam int AGE_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W    = $clog2(ENTRIES + 1);
  localparam int CMP_W    = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [FIELD_W-1:0] key;
    logic [FIELD_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic [FIELD_W-1:0] read_value;
    logic               evicted;
  } res_t;

endpackage

// ----- rtl/core/lkv_store.sv -----
module lkv_store (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  lkv_pkg::req_t           req,
  input  logic [lkv_pkg::CAP_W-1:0] cap,
  output lkv_pkg::res_t           res
);
  import lkv_pkg::*;

  logic [ENTRIES-1:0]  valid_r, valid_nxt;
  logic [AGE_W-1:0]    age_r   [ENTRIES];
  logic [AGE_W-1:0]    age_nxt [ENTRIES];
  logic [KEY_BITS-1:0] key_r   [ENTRIES];
  logic [VAL_BITS-1:0] val_r   [ENTRIES];
  logic [CNT_W-1:0]    n_r, n_nxt;

  logic [KEY_BITS-1:0] key_in;
  logic [VAL_BITS-1:0] val_in;
  logic [CMP_W-1:0]    cap_ext, cap_eff, n_ext;
  logic [AGE_W-1:0]    n_m1, n_m2, found_age;
  logic [VAL_BITS-1:0] found_val;
  logic [ENTRIES-1:0]  match, found, lru, second, victim, spare, touch_sel;
  logic [CNT_W-1:0]    thr;
  logic                hit, full, over;
  logic                touch_en, write_en, ins, evict_hit, evict_miss;

  assign key_in = req.key[KEY_BITS-1:0];
  assign val_in = req.value[VAL_BITS-1:0];

  always_comb begin
    cap_ext = CMP_W'(cap);
    if (cap_ext == '0) begin
      cap_eff = CMP_W'(1);
    end else if (cap_ext > CMP_W'(ENTRIES)) begin
      cap_eff = CMP_W'(ENTRIES);
    end else begin
      cap_eff = cap_ext;
    end
  end

  assign n_ext = CMP_W'(n_r);
  assign n_m1  = AGE_W'(n_r - CNT_W'(1));
  assign n_m2  = AGE_W'(n_r - CNT_W'(2));
  assign full  = n_ext >= cap_eff;
  assign over  = n_ext > cap_eff;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match[i]  = valid_r[i] && (key_r[i] == key_in);
      lru[i]    = valid_r[i] && (age_r[i] == n_m1);
      second[i] = valid_r[i] && (age_r[i] == n_m2);
    end
  end

  // isolate lowest matching entry and lowest free slot
  assign found = match & (~match + ENTRIES'(1));
  assign spare = ~valid_r & (valid_r + ENTRIES'(1));
  assign hit   = |found;

  always_comb begin
    found_age = '0;
    found_val = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (found[i]) begin
        found_age = found_age | age_r[i];
        found_val = found_val | val_r[i];
      end
    end
  end

  assign victim = (|(found & lru)) ? second : lru;

  always_comb begin
    touch_en   = 1'b0;
    write_en   = 1'b0;
    ins        = 1'b0;
    evict_hit  = 1'b0;
    evict_miss = 1'b0;
    touch_sel  = '0;
    thr        = '0;
    if (req.op == OP_GET) begin
      if (hit) begin
        touch_en  = 1'b1;
        touch_sel = found;
        thr       = CNT_W'(found_age);
      end
    end else if (hit) begin
      touch_en  = 1'b1;
      write_en  = 1'b1;
      touch_sel = found;
      thr       = CNT_W'(found_age);
      evict_hit = over;
    end else if (full) begin
      touch_en   = 1'b1;
      write_en   = 1'b1;
      touch_sel  = lru;
      thr        = CNT_W'(n_m1);
      evict_miss = 1'b1;
    end else begin
      touch_en  = 1'b1;
      write_en  = 1'b1;
      touch_sel = spare;
      thr       = n_r;
      ins       = 1'b1;
    end
  end

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      valid_nxt[i] = valid_r[i];
      age_nxt[i]   = age_r[i];
      if (touch_en) begin
        if (touch_sel[i]) begin
          valid_nxt[i] = 1'b1;
          age_nxt[i]   = '0;
        end else if (valid_r[i] && (CNT_W'(age_r[i]) < thr)) begin
          age_nxt[i] = age_r[i] + AGE_W'(1);
        end
      end
      if (evict_hit && victim[i]) begin
        valid_nxt[i] = 1'b0;
        age_nxt[i]   = '0;
      end
    end
  end

  always_comb begin
    n_nxt = n_r;
    if (ins) begin
      n_nxt = n_r + CNT_W'(1);
    end else if (evict_hit) begin
      n_nxt = n_r - CNT_W'(1);
    end
  end

  always_comb begin
    res.hit        = hit;
    res.read_value = '0;
    if (req.op == OP_GET && hit) begin
      res.read_value = FIELD_W'(found_val);
    end
    res.evicted = evict_hit | evict_miss;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      n_r     <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        age_r[i] <= '0;
      end
    end else if (en) begin
      valid_r <= valid_nxt;
      n_r     <= n_nxt;
      for (int i = 0; i < ENTRIES; i++) begin
        age_r[i] <= age_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && write_en) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (touch_sel[i]) begin
          key_r[i] <= key_in;
          val_r[i] <= val_in;
        end
      end
    end
  end

  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    n_r == CNT_W'($countones(valid_r)))
    else $error("fill count out of step with valid bits");

  a_found_unique: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match))
    else $error("key stored in more than one entry");

  a_evict_on_put: assert property (@(posedge clk) disable iff (!rst_n)
    (en && res.evicted) |-> (req.op == OP_PUT))
    else $error("eviction on a get");

  a_victim_present: assert property (@(posedge clk) disable iff (!rst_n)
    (en && (evict_hit || evict_miss)) |-> $onehot(evict_hit ? victim : lru))
    else $error("no single least recent entry");

endmodule

// ----- rtl/core/lru_key_value_cache_unit.sv -----
// Path: input register, then result register; an accepted word is held in the input register
// and moves into the result register once no unread result is held or out_ready is high.
// Throughput: one word per cycle while out_ready takes each result; the parallel key compare
// and rank update over all 16 entries completes in the single pass between the two registers.
// Reset: synchronous, active low; clears entry valid bits, ranks, fill count and the valid
// flags of both pipeline registers, and sets capacity to 16. Stored keys, values and
// pipeline payloads are not reset.
module lru_key_value_cache_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [lkv_pkg::CAP_W-1:0]   cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_op,
  input  logic signed [lkv_pkg::FIELD_W-1:0] in_key,
  input  logic signed [lkv_pkg::FIELD_W-1:0] in_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_hit,
  output logic signed [lkv_pkg::FIELD_W-1:0] out_read_value,
  output logic                        out_evicted
);
  import lkv_pkg::*;

  logic             in_valid_r, out_valid_r;
  logic [CAP_W-1:0] cap_r;
  req_t             req_r;
  res_t             res, res_r;
  logic             advance;

  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;
  assign cfg_ready = 1'b1;

  lkv_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (advance),
    .req   (req_r),
    .cap   (cap_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cap_r       <= CAP_RESET;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid) begin
        cap_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r.op    <= op_t'(in_op);
      req_r.key   <= in_key;
      req_r.value <= in_value;
    end
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = res_r.hit;
  assign out_read_value = res_r.read_value;
  assign out_evicted    = res_r.evicted;

endmodule
